// ===== hdl/afpe_pkg.sv =====
// ============================================================================
// afpe_pkg: shared types and constants for the fade and pan envelope core
// Frame payload, configuration register indexes, effect codes and the
// request and result bundles of the serial divider.
// ============================================================================
`default_nettype none

package afpe_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RAMP_W    = 24;
    localparam int TOTAL_W   = 31;
    localparam int COUNT_W   = 32;
    localparam int PROD_W    = SAMPLE_W + RAMP_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEREO       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_FRAMES  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = CFG_IDX_W'(3);

    localparam logic [1:0] MODE_FADE_IN  = 2'd0;
    localparam logic [1:0] MODE_FADE_OUT = 2'd1;
    localparam logic [1:0] MODE_PAN      = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_frame_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_frame_out;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [RAMP_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } t_div_res;

endpackage

`default_nettype wire

// ===== hdl/afpe_if.sv =====
// ============================================================================
// afpe_if: channel interfaces of the fade and pan envelope core
// Valid/ready frame channels for input and output, and the register write
// channel.
// ============================================================================
`default_nettype none

interface afpe_in_if import afpe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_frame_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface afpe_out_if import afpe_pkg::*; ();
    logic       valid;
    logic       ready;
    t_frame_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface afpe_cfg_if import afpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/audio_fade_and_pan_envelope_core.sv =====
// ============================================================================
// audio_fade_and_pan_envelope_core: linear fade and pan for 16-bit PCM
// Scales each frame by a gain ramp from a running frame count, with one
// shared multiplier and serial divider.
// ============================================================================
// One frame is taken at a time; the input is not ready until the frame has
// been handed to the output register, which can still hold it while the next
// frame comes in. A frame whose channels only pass or are zeroed goes from
// acceptance through the plan state, one channel state per side and the
// push state to the output register. Each channel that is scaled adds one
// multiply, the divider load, 16 divider steps, one quotient bit per cycle,
// and the taking of the quotient. The divider is the shared unit that
// sets the pace. Registers are written through the configuration
// channel, which is always ready; write them only while no frame is in
// flight. The frame counter starts from zero at reset and saturates.
`default_nettype none

module audio_fade_and_pan_envelope_core import afpe_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    afpe_in_if.sink    i_in,
    afpe_out_if.source o_out,
    afpe_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_CHAN,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_ZERO,
        OP_SCALE
    } t_op;

    t_state r_state;

    logic [1:0]         r_mode;
    logic               r_stereo;
    logic [RAMP_W-1:0]  r_ramp;
    logic [TOTAL_W-1:0] r_total;
    logic [COUNT_W-1:0] r_frames;

    logic [COUNT_W-1:0]         r_k;
    logic signed [SAMPLE_W-1:0] r_left_in;
    logic signed [SAMPLE_W-1:0] r_right_in;
    t_op                        r_op_l;
    t_op                        r_op_r;
    logic [RAMP_W-1:0]          r_gain_l;
    logic [RAMP_W-1:0]          r_gain_r;
    logic                       r_ch;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_res_l;
    logic signed [SAMPLE_W-1:0] r_res_r;
    logic                       r_out_valid;
    t_frame_out                 r_out_data;

    logic               in_fire;
    logic [COUNT_W-1:0] ramp_ext;
    logic [COUNT_W-1:0] total_ext;
    logic               k_lt_r;
    logic [RAMP_W-1:0]  kp1;
    logic [COUNT_W-1:0] s_cnt;
    logic [COUNT_W-1:0] t_cnt;
    t_op                plan_l;
    t_op                plan_r;
    logic [RAMP_W-1:0]  plan_gain_l;
    logic [RAMP_W-1:0]  plan_gain_r;

    t_op                        cur_op;
    logic [RAMP_W-1:0]          cur_gain;
    logic signed [SAMPLE_W-1:0] cur_x;
    logic [SAMPLE_W-1:0]        cur_mag;
    logic signed [SAMPLE_W-1:0] cur_direct;
    logic signed [SAMPLE_W-1:0] div_signed;

    t_div_req div_req;
    t_div_res div_res;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_FADE_IN;
            r_stereo <= 1'b1;
            r_ramp   <= '0;
            r_total  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_EFFECT_MODE:  r_mode   <= i_cfg.data[1:0];
                REG_STEREO:       r_stereo <= i_cfg.data[0];
                REG_RAMP_FRAMES:  r_ramp   <= i_cfg.data[RAMP_W-1:0];
                REG_TOTAL_FRAMES: r_total  <= i_cfg.data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign ramp_ext  = {{(COUNT_W-RAMP_W){1'b0}}, r_ramp};
    assign total_ext = {{(COUNT_W-TOTAL_W){1'b0}}, r_total};
    assign k_lt_r    = r_k < ramp_ext;
    assign kp1       = r_k[RAMP_W-1:0] + RAMP_W'(1);
    assign s_cnt     = (r_k < total_ext) ? total_ext - r_k : '0;
    assign t_cnt     = (s_cnt != '0) ? s_cnt - COUNT_W'(1) : '0;

    always_comb begin
        plan_l      = OP_PASS;
        plan_r      = OP_PASS;
        plan_gain_l = kp1;
        plan_gain_r = kp1;
        if (r_ramp != '0) begin
            case (r_mode)
                MODE_FADE_IN: begin
                    if (k_lt_r) begin
                        plan_l = OP_SCALE;
                        plan_r = OP_SCALE;
                    end
                end
                MODE_FADE_OUT: begin
                    plan_gain_l = t_cnt[RAMP_W-1:0];
                    plan_gain_r = t_cnt[RAMP_W-1:0];
                    if (s_cnt == '0) begin
                        plan_l = OP_ZERO;
                    end else if (s_cnt < ramp_ext) begin
                        plan_l = OP_SCALE;
                    end
                    if (t_cnt == '0) begin
                        plan_r = OP_ZERO;
                    end else if (t_cnt < ramp_ext) begin
                        plan_r = OP_SCALE;
                    end
                end
                MODE_PAN: begin
                    plan_gain_l = r_ramp - kp1;
                    if (k_lt_r) begin
                        plan_l = OP_SCALE;
                        plan_r = OP_SCALE;
                    end else begin
                        plan_l = OP_ZERO;
                    end
                end
                default: ;
            endcase
        end
        if (!r_stereo) begin
            plan_r = OP_ZERO;
        end
    end

    assign cur_op     = r_ch ? r_op_r : r_op_l;
    assign cur_gain   = r_ch ? r_gain_r : r_gain_l;
    assign cur_x      = r_ch ? r_right_in : r_left_in;
    assign cur_mag    = cur_x[SAMPLE_W-1] ? (~cur_x) + SAMPLE_W'(1) : cur_x;
    assign cur_direct = (cur_op == OP_ZERO) ? '0 : cur_x;
    assign div_signed = r_neg ? $signed(SAMPLE_W'(~div_res.quotient + SAMPLE_W'(1)))
                              : $signed(div_res.quotient);

    assign div_req.start    = (r_state == S_DIVGO);
    assign div_req.dividend = r_prod;
    assign div_req.divisor  = r_ramp;

    afpe_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
            r_ch        <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_k        <= r_frames;
                        r_left_in  <= i_in.data.left_sample;
                        r_right_in <= i_in.data.right_sample;
                        if (r_frames != '1) begin
                            r_frames <= r_frames + COUNT_W'(1);
                        end
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_op_l   <= plan_l;
                    r_op_r   <= plan_r;
                    r_gain_l <= plan_gain_l;
                    r_gain_r <= plan_gain_r;
                    r_ch     <= 1'b0;
                    r_state  <= S_CHAN;
                end
                S_CHAN: begin
                    if (cur_op == OP_SCALE) begin
                        r_state <= S_MUL;
                    end else begin
                        if (r_ch) begin
                            r_res_r <= cur_direct;
                            r_state <= S_PUSH;
                        end else begin
                            r_res_l <= cur_direct;
                            r_ch    <= 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= {{RAMP_W{1'b0}}, cur_mag} * {{SAMPLE_W{1'b0}}, cur_gain};
                    r_neg   <= cur_x[SAMPLE_W-1];
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_res.done) begin
                        if (r_ch) begin
                            r_res_r <= div_signed;
                            r_state <= S_PUSH;
                        end else begin
                            r_res_l <= div_signed;
                            r_ch    <= 1'b1;
                            r_state <= S_CHAN;
                        end
                    end
                end
                S_PUSH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid          <= 1'b1;
                        r_out_data.left_out  <= r_res_l;
                        r_out_data.right_out <= r_res_r;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/afpe_serdiv.sv =====
// ============================================================================
// afpe_serdiv: restoring serial divider
// Divides a gain product by the ramp length, one quotient bit per cycle.
// The quotient is known to fit in the sample width, so only that many
// steps run.
// ============================================================================
`default_nettype none

module afpe_serdiv import afpe_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_res      o_res
);

    localparam int CNT_W = $clog2(SAMPLE_W + 1);

    logic [RAMP_W-1:0]   r_rem;
    logic [SAMPLE_W-1:0] r_low;
    logic [RAMP_W-1:0]   r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [RAMP_W:0]   part;
    logic [RAMP_W+1:0] diff;

    assign part = {r_rem, r_low[SAMPLE_W-1]};
    assign diff = {1'b0, part} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SAMPLE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[PROD_W-1:SAMPLE_W];
            r_low <= i_req.dividend[SAMPLE_W-1:0];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (!diff[RAMP_W+1]) begin
                r_rem <= diff[RAMP_W-1:0];
                r_low <= {r_low[SAMPLE_W-2:0], 1'b1};
            end else begin
                r_rem <= part[RAMP_W-1:0];
                r_low <= {r_low[SAMPLE_W-2:0], 1'b0};
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_low;

endmodule

`default_nettype wire
